### sv/dbpm_pkg.sv
// Package: constants, status codes and symbol classification for the bracket matcher.
`timescale 1ns / 1ps
`default_nettype none

package dbpm_pkg;

  localparam int MAX_LEN   = 1024;
  localparam int NUM_KINDS = 4;

  localparam int SYM_W  = 8;
  localparam int KIND_W = 2;
  localparam int POS_AW = $clog2(MAX_LEN);      // position / stack slot index
  localparam int CNT_W  = POS_AW + 1;           // counter that can hold MAX_LEN
  localparam int STK_AW = KIND_W + POS_AW;      // stack memory address
  localparam int STK_DEPTH = NUM_KINDS * MAX_LEN;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ILLEGAL    = 3'd1,
    ST_UNBALANCED = 3'd2,
    ST_UNCLOSED   = 3'd3,
    ST_OVERFLOW   = 3'd4
  } status_t;

  localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ANGLE  = 2'd3;

  localparam logic [SYM_W-1:0] CH_DOT      = 8'h2E;
  localparam logic [SYM_W-1:0] CH_RND_OPEN = 8'h28;
  localparam logic [SYM_W-1:0] CH_RND_CLS  = 8'h29;
  localparam logic [SYM_W-1:0] CH_CRL_OPEN = 8'h7B;
  localparam logic [SYM_W-1:0] CH_CRL_CLS  = 8'h7D;
  localparam logic [SYM_W-1:0] CH_SQR_OPEN = 8'h5B;
  localparam logic [SYM_W-1:0] CH_SQR_CLS  = 8'h5D;
  localparam logic [SYM_W-1:0] CH_ANG_OPEN = 8'h3C;
  localparam logic [SYM_W-1:0] CH_ANG_CLS  = 8'h3E;

  typedef struct packed {
    logic              is_dot;
    logic              bracket;
    logic              is_open;
    logic [KIND_W-1:0] kind;
  } sym_class_t;

  // Stack memory access request, one per accepted symbol at most.
  typedef struct packed {
    logic              we;
    logic [STK_AW-1:0] waddr;
    logic [POS_AW-1:0] wdata;
    logic              re;
    logic [STK_AW-1:0] raddr;
  } stk_req_t;

  function automatic sym_class_t classify(logic [SYM_W-1:0] sym);
    sym_class_t c;
    c = '{is_dot: 1'b0, bracket: 1'b1, is_open: 1'b0, kind: KIND_ROUND};
    case (sym)
      CH_DOT: begin
        c.is_dot  = 1'b1;
        c.bracket = 1'b0;
      end
      CH_RND_OPEN: begin c.is_open = 1'b1; c.kind = KIND_ROUND;  end
      CH_RND_CLS:  begin c.kind = KIND_ROUND;  end
      CH_CRL_OPEN: begin c.is_open = 1'b1; c.kind = KIND_CURLY;  end
      CH_CRL_CLS:  begin c.kind = KIND_CURLY;  end
      CH_SQR_OPEN: begin c.is_open = 1'b1; c.kind = KIND_SQUARE; end
      CH_SQR_CLS:  begin c.kind = KIND_SQUARE; end
      CH_ANG_OPEN: begin c.is_open = 1'b1; c.kind = KIND_ANGLE;  end
      CH_ANG_CLS:  begin c.kind = KIND_ANGLE;  end
      default: begin
        c.bracket = 1'b0;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/dbpm_if.sv
// Interfaces: symbol input channel and pair result channel.
`timescale 1ns / 1ps
`default_nettype none

interface dbpm_in_if;
  import dbpm_pkg::*;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;
  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface dbpm_out_if;
  import dbpm_pkg::*;
  logic              valid;
  logic              ready;
  logic              pair_valid;
  logic [POS_AW-1:0] open_pos;
  logic [POS_AW-1:0] close_pos;
  logic [KIND_W-1:0] kind;
  logic [2:0]        status;
  logic              done_res;
  modport source (output valid, output pair_valid, output open_pos, output close_pos,
                  output kind, output status, output done_res, input ready);
  modport sink   (input valid, input pair_valid, input open_pos, input close_pos,
                  input kind, input status, input done_res, output ready);
endinterface

`default_nettype wire

### sv/dbpm_stack_mem.sv
// Open-position stack memory: all bracket kinds, one write and one read port.
`timescale 1ns / 1ps
`default_nettype none

module dbpm_stack_mem (
  input  logic                              clk,
  input  dbpm_pkg::stk_req_t                req,
  output logic [dbpm_pkg::POS_AW-1:0]       rdata
);
  import dbpm_pkg::*;

  logic [POS_AW-1:0] mem [STK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

### sv/dot_bracket_pair_matcher_top.sv
// Top level: dot-bracket pair matcher with per-kind stacks of open positions.
// Result path: stack read and stage-1 register, then the output register.
// Throughput: 1 symbol per cycle while the output is taken; push/pop is one memory access per symbol.
// Reset: rst_n synchronous, active low; clears position, error, stack depths and pipeline valids.
// Stack memory contents are not cleared; depths gate every read, so no clearing pass.
// The symbol marked last returns position, error and stack depths to their reset state.
`timescale 1ns / 1ps
`default_nettype none

module dot_bracket_pair_matcher_top (
  input  logic        clk,
  input  logic        rst_n,
  dbpm_in_if.sink     in_ch,
  dbpm_out_if.source  out_ch
);
  import dbpm_pkg::*;

  // ---------------------------------------------------------------------------
  // Architectural state, updated at each input transfer
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] pos_r, pos_nxt;
  status_t          err_r, err_nxt;
  logic [CNT_W-1:0] depth_r   [NUM_KINDS];
  logic [CNT_W-1:0] depth_nxt [NUM_KINDS];

  // Stage 1: result meta waiting on the stack read
  logic              s1_valid_r;
  logic              s1_pair_r;
  logic [POS_AW-1:0] s1_close_r;
  logic [KIND_W-1:0] s1_kind_r;
  status_t           s1_status_r;
  logic              s1_done_r;

  // Stage 2: output register
  logic              out_valid_r;
  logic              out_pair_r;
  logic [POS_AW-1:0] out_open_r;
  logic [POS_AW-1:0] out_close_r;
  logic [KIND_W-1:0] out_kind_r;
  status_t           out_status_r;
  logic              out_done_r;

  logic              in_xfer;
  logic              s1_adv;
  logic              in_rdy;
  sym_class_t        cls;
  logic              push, pop, any_open;
  logic [CNT_W-1:0]  cur_depth;
  logic [CNT_W-1:0]  dec_depth;
  status_t           status_nxt;
  stk_req_t          req;
  logic [POS_AW-1:0] rd_pos;

  // Output stage frees when empty or taken; stage 1 then moves up, and a new
  // symbol may enter in the same cycle.
  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_rdy      = !s1_valid_r || s1_adv;
  assign in_ch.ready = in_rdy;
  assign in_xfer     = in_ch.valid && in_rdy;

  assign cls       = classify(in_ch.symbol);
  assign cur_depth = depth_r[cls.kind];
  assign dec_depth = cur_depth - CNT_W'(1);

  // ---------------------------------------------------------------------------
  // Per-symbol update: first error wins, afterwards symbols are only counted
  // ---------------------------------------------------------------------------
  always_comb begin
    err_nxt = err_r;
    push    = 1'b0;
    pop     = 1'b0;
    for (int i = 0; i < NUM_KINDS; i++) begin
      depth_nxt[i] = depth_r[i];
    end
    if (err_r == ST_OK) begin
      if (pos_r >= CNT_W'(MAX_LEN)) begin
        err_nxt = ST_OVERFLOW;
      end else if (!cls.is_dot) begin
        if (!cls.bracket) begin
          err_nxt = ST_ILLEGAL;
        end else if (cls.is_open) begin
          if (cur_depth >= CNT_W'(MAX_LEN)) begin
            err_nxt = ST_OVERFLOW;
          end else begin
            push = 1'b1;
            depth_nxt[cls.kind] = cur_depth + CNT_W'(1);
          end
        end else begin
          if (cur_depth == '0) begin
            err_nxt = ST_UNBALANCED;
          end else begin
            pop = 1'b1;
            depth_nxt[cls.kind] = dec_depth;
          end
        end
      end
    end

    // position saturates at MAX_LEN
    pos_nxt = (pos_r < CNT_W'(MAX_LEN)) ? pos_r + CNT_W'(1) : pos_r;

    any_open = 1'b0;
    for (int i = 0; i < NUM_KINDS; i++) begin
      any_open = any_open | (depth_nxt[i] != '0);
    end
    status_nxt = err_nxt;
    if (in_ch.last && err_nxt == ST_OK && any_open) begin
      status_nxt = ST_UNCLOSED;
    end
  end

  // Stack memory: push writes the slot at the depth, pop reads the slot below.
  // A pop right after a push to the same slot reads after the write edge, so
  // no forwarding is needed.
  always_comb begin
    req.we    = in_xfer && push;
    req.waddr = {cls.kind, cur_depth[POS_AW-1:0]};
    req.wdata = pos_r[POS_AW-1:0];
    req.re    = in_xfer && pop;
    req.raddr = {cls.kind, dec_depth[POS_AW-1:0]};
  end

  dbpm_stack_mem u_stack_mem (
    .clk   (clk),
    .req   (req),
    .rdata (rd_pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      err_r <= ST_OK;
      for (int i = 0; i < NUM_KINDS; i++) begin
        depth_r[i] <= '0;
      end
    end else if (in_xfer) begin
      if (in_ch.last) begin
        pos_r <= '0;
        err_r <= ST_OK;
        for (int i = 0; i < NUM_KINDS; i++) begin
          depth_r[i] <= '0;
        end
      end else begin
        pos_r <= pos_nxt;
        err_r <= err_nxt;
        for (int i = 0; i < NUM_KINDS; i++) begin
          depth_r[i] <= depth_nxt[i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result pipeline
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_rdy) begin
        s1_valid_r <= in_xfer;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pair_r   <= pop;
      s1_close_r  <= pos_r[POS_AW-1:0];
      s1_kind_r   <= pop ? cls.kind : KIND_ROUND;
      s1_status_r <= status_nxt;
      s1_done_r   <= in_ch.last;
    end
  end

  // rd_pos only changes on a pop transfer, which cannot happen while stage 1
  // is stalled, so it is still the right value here.
  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_pair_r   <= s1_pair_r;
      out_open_r   <= s1_pair_r ? rd_pos : '0;
      out_close_r  <= s1_close_r;
      out_kind_r   <= s1_kind_r;
      out_status_r <= s1_status_r;
      out_done_r   <= s1_done_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pair_valid = out_pair_r;
  assign out_ch.open_pos   = out_open_r;
  assign out_ch.close_pos  = out_close_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.done_res   = out_done_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.we && req.re))
    else $error("stack push and pop in the same cycle");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.last) |=> (pos_r == '0 && err_r == ST_OK))
    else $error("state not cleared after last symbol");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= CNT_W'(MAX_LEN))
    else $error("position counter beyond saturation");

  a_pair_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pair_r) |->
      (out_status_r == ST_OK || out_status_r == ST_UNCLOSED))
    else $error("pair reported with an error status");

endmodule

`default_nettype wire
